FILE: design/tgt_pkg.sv
// Shared constants and register codes for the tripod gait trajectory block.
`timescale 1ns / 1ps
`default_nettype none
package tgt_pkg;

  localparam int unsigned LEG_COUNT = 6;
  localparam int unsigned LEG_W     = 3;
  localparam int unsigned STRIDE_W  = 14;
  localparam int unsigned HEIGHT_W  = 14;
  localparam int unsigned CYC_W     = 20;
  localparam int unsigned POS_W     = 15;
  localparam int unsigned SINE_W    = 17;   // Q16 sine, 1.0 inclusive

  localparam int unsigned REST_X = 6400;
  localparam logic signed [POS_W-1:0] GROUND_Z = -15'sd6400;

  // legs 0, 3 and 4 run on the unshifted phase
  localparam logic [LEG_COUNT-1:0] GROUP_A_MASK = 6'b011001;

  // pi/2 in Q30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TIME    = 2'd2;

endpackage
`default_nettype wire

FILE: design/tgt_front.sv
// Front end: accepts ticks, advances the phase timer and divides it down to a phase.
`timescale 1ns / 1ps
`default_nettype none
module tgt_front
  import tgt_pkg::*;
#(
  parameter int PHASE_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CYC_W-1:0]      cycle_eff,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CYC_W-1:0]      tick_time,
  output logic                       push,
  output logic [PHASE_BITS-1:0]      push_data,
  input  wire logic                  full
);

  localparam int CNT_W = $clog2(PHASE_BITS) + 1;

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_ADD  = 5'b00010,
    F_WRAP = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_t;

  front_state_t state;
  logic [CYC_W-1:0]      tick;
  logic [CYC_W-1:0]      phase_timer;
  logic [CYC_W:0]        sum;
  logic [CYC_W-1:0]      rem;
  logic [PHASE_BITS-1:0] quot;
  logic [CNT_W-1:0]      count;

  logic [CYC_W-1:0] tick_sat;
  logic [CYC_W:0]   wrap1;
  logic [CYC_W-1:0] wrapped;
  logic [CYC_W:0]   rem_dbl;
  logic             qbit;
  logic [CYC_W:0]   rem_sub;

  always_comb begin
    tick_sat = (tick > cycle_eff) ? cycle_eff : tick;
    wrap1 = (sum >= {1'b0, cycle_eff}) ? sum - {1'b0, cycle_eff} : sum;
    wrapped = (wrap1 >= {1'b0, cycle_eff}) ? '0 : wrap1[CYC_W-1:0];
    rem_dbl = {rem, 1'b0};
    qbit = rem_dbl >= {1'b0, cycle_eff};
    rem_sub = rem_dbl - {1'b0, cycle_eff};
  end

  assign in_stall  = (state != F_IDLE);
  assign push      = (state == F_PUSH) && !full;
  assign push_data = quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      phase_timer <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            tick <= tick_time;
            state <= F_ADD;
          end
        end
        F_ADD: begin
          sum <= {1'b0, phase_timer} + {1'b0, tick_sat};
          state <= F_WRAP;
        end
        F_WRAP: begin
          phase_timer <= wrapped;
          rem <= wrapped;
          count <= '0;
          state <= F_DIV;
        end
        F_DIV: begin
          // restoring divide, one quotient bit per cycle
          rem <= qbit ? rem_sub[CYC_W-1:0] : rem_dbl[CYC_W-1:0];
          quot <= {quot[PHASE_BITS-2:0], qbit};
          count <= count + 1'b1;
          if (count == CNT_W'(PHASE_BITS - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/tgt_queue.sv
// Two-entry phase queue between front and back.
`timescale 1ns / 1ps
`default_nettype none
module tgt_queue
  import tgt_pkg::*;
#(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  logic [WIDTH-1:0] entry [0:1];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full     = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/tgt_back.sv
// Back end: turns one phase into six leg foot targets through the sine ROM.
`timescale 1ns / 1ps
`default_nettype none
module tgt_back
  import tgt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [STRIDE_W-1:0]    stride_len,
  input  wire logic [HEIGHT_W-1:0]    lift_height,
  input  wire logic                   q_empty,
  input  wire logic [PHASE_BITS-1:0]  q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [LEG_W-1:0]            leg,
  output logic signed [POS_W-1:0]     foot_x,
  output logic signed [POS_W-1:0]     foot_z,
  output logic                        swinging,
  output logic                        last
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int QM_W   = PHASE_BITS - 1 + IDX_W;
  localparam int PX_W   = STRIDE_W + PHASE_BITS - 1;
  localparam int LIFT_W = HEIGHT_W + SINE_W;
  localparam int XW     = POS_W + 2;

  typedef logic [SINE_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // Taylor series denominators (2n)(2n+1) for n = 1..8
  function automatic longint unsigned taylor_div(input int n, input longint unsigned val);
    case (n)
      1:       return val / 64'd6;
      2:       return val / 64'd20;
      3:       return val / 64'd42;
      4:       return val / 64'd72;
      5:       return val / 64'd110;
      6:       return val / 64'd156;
      7:       return val / 64'd210;
      default: return val / 64'd272;
    endcase
  endfunction

  // quarter-wave sine in Q16 from a 9-term Q30 Taylor series
  function automatic rom_t build_sine();
    rom_t             rom;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint           sum;
    longint unsigned  rnd;
    int               k;
    int               n;
    for (k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * longint'(k)) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (n = 1; n <= 8; n++) begin
        term = taylor_div(n, (term * x2) >> 30);
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      rnd = (longint'(sum) + 64'd8192) >> 14;
      rom[k] = rnd[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine();

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_CALC = 4'b0010,
    B_LIFT = 4'b0100,
    B_EMIT = 4'b1000
  } back_state_t;

  back_state_t state;
  logic [PHASE_BITS-1:0] phase;
  logic [LEG_W-1:0]      leg_cnt;
  logic                  swing;
  logic [SINE_W-1:0]     sine_q;
  logic [PX_W-1:0]       prod_x;
  logic [LIFT_W-1:0]     lift_prod;

  logic [PHASE_BITS-1:0] p;
  logic [PHASE_BITS-2:0] q;
  logic [QM_W-1:0]       qmul;
  logic [QM_W-1:0]       idx_full;
  logic [IDX_W-1:0]      idx;
  logic [STRIDE_W-1:0]   travel;
  logic [XW-1:0]         half_stride;
  logic [XW-1:0]         x_next;
  logic [LIFT_W:0]       lift_rnd;
  logic [POS_W-1:0]      z_next;
  logic                  emit;

  always_comb begin
    // group B legs run half a cycle out of step
    p = GROUP_A_MASK[leg_cnt] ? phase : {~phase[PHASE_BITS-1], phase[PHASE_BITS-2:0]};
    if (!p[PHASE_BITS-2]) q = p[PHASE_BITS-2:0];
    else q = (PHASE_BITS-1)'(({1'b1, {(PHASE_BITS-1){1'b0}}}) - p);
    qmul = QM_W'(q) * QM_W'(SINE_TABLE_DEPTH);
    idx_full = qmul >> (PHASE_BITS - 2);
    if (idx_full > QM_W'(SINE_TABLE_DEPTH)) idx = IDX_W'(SINE_TABLE_DEPTH);
    else idx = idx_full[IDX_W-1:0];

    travel = prod_x[PX_W-1 -: STRIDE_W];
    half_stride = XW'(stride_len >> 1);
    if (swing) x_next = XW'(REST_X) - half_stride + XW'(travel);
    else x_next = XW'(REST_X) + half_stride - XW'(travel);

    lift_rnd = {1'b0, lift_prod} + (LIFT_W+1)'(32768);
    z_next = swing ? GROUND_Z + POS_W'(lift_rnd >> 16) : GROUND_Z;

    emit = (state == B_EMIT) && (!out_valid || !out_stall);
  end

  assign q_pop = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        if (!q_empty) phase <= q_data;
      end
      B_CALC: begin
        swing <= !p[PHASE_BITS-1];
        sine_q <= SINE_ROM[idx];
        // stance offset p - 1/2 has the same low bits as p
        prod_x <= PX_W'(stride_len) * PX_W'(p[PHASE_BITS-2:0]);
      end
      B_LIFT: begin
        lift_prod <= LIFT_W'(lift_height) * LIFT_W'(sine_q);
      end
      B_EMIT: begin
        if (emit) begin
          leg <= leg_cnt;
          foot_x <= x_next[POS_W-1:0];
          foot_z <= z_next;
          swinging <= swing;
          last <= (leg_cnt == LEG_W'(LEG_COUNT - 1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      leg_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            leg_cnt <= '0;
            state <= B_CALC;
          end
        end
        B_CALC: state <= B_LIFT;
        B_LIFT: state <= B_EMIT;
        B_EMIT: begin
          if (emit) begin
            leg_cnt <= leg_cnt + 1'b1;
            state <= (leg_cnt == LEG_W'(LEG_COUNT - 1)) ? B_IDLE : B_CALC;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: design/tripod_gait_trajectory.sv
// Top level of the tripod gait trajectory generator.
// Usage:
//  - Input channel (in_valid / in_stall / tick_time): one request per servo
//    tick carrying the elapsed time in 1/16 ms. Each request yields six
//    result requests, one per leg in order 0..5, last set on leg 5.
//  - Output channel (out_valid / out_stall / leg, foot_x, foot_z, swinging,
//    last): foot targets in 1/64 mm, held steady while stalled.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
//    stride, 1 step lift height, 2 gait period; other indices are dropped.
//    cfg_ready is always high; write only while the block is idle.
//  - Front end: saturating add and wrap of the phase timer, then a
//    restoring divider producing one phase bit per cycle. A new tick is
//    taken only once the last phase has been pushed into the queue.
//  - Back end: each leg steps through ROM read, lift multiply and emit;
//    a phase is fetched per tick from a two-entry queue that sits in between.
//  - Output stall backs up into the queue, then into in_stall.
//  - Synchronous reset clears the phase timer, queue and both sequencers and
//    restores the register defaults (3200, 2560, 16000).
`timescale 1ns / 1ps
`default_nettype none
module tripod_gait_trajectory
  import tgt_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int PHASE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [CYC_W-1:0]       tick_time,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [LEG_W-1:0]            leg,
  output logic signed [POS_W-1:0]     foot_x,
  output logic signed [POS_W-1:0]     foot_z,
  output logic                        swinging,
  output logic                        last
);

  logic [STRIDE_W-1:0] stride_len;
  logic [HEIGHT_W-1:0] lift_height;
  logic [CYC_W-1:0]    gait_period;
  logic [CYC_W-1:0]    cycle_eff;

  logic                  q_push;
  logic [PHASE_BITS-1:0] q_push_data;
  logic                  q_full;
  logic                  q_pop;
  logic [PHASE_BITS-1:0] q_pop_data;
  logic                  q_empty;

  assign cfg_ready = 1'b1;
  // a zero period behaves as one
  assign cycle_eff = (gait_period == '0) ? CYC_W'(1) : gait_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride_len <= STRIDE_W'(3200);
      lift_height <= HEIGHT_W'(2560);
      gait_period <= CYC_W'(16000);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STRIDE_LENGTH: stride_len <= cfg_data[STRIDE_W-1:0];
        REG_STEP_HEIGHT:   lift_height <= cfg_data[HEIGHT_W-1:0];
        REG_CYCLE_TIME:    gait_period <= cfg_data[CYC_W-1:0];
        default: ;
      endcase
    end
  end

  tgt_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cycle_eff (cycle_eff),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .tick_time (tick_time),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full)
  );

  tgt_queue #(
    .WIDTH(PHASE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  tgt_back #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .PHASE_BITS(PHASE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .stride_len    (stride_len),
    .lift_height   (lift_height),
    .q_empty       (q_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .leg           (leg),
    .foot_x        (foot_x),
    .foot_z        (foot_z),
    .swinging      (swinging),
    .last          (last)
  );

endmodule
`default_nettype wire
